// ===== design/delayed_message_queue_top_macros.svh =====
// Assertion macros used by the delayed message queue checker.
`ifndef DELAYED_MESSAGE_QUEUE_TOP_MACROS_SVH
`define DELAYED_MESSAGE_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dmq_pkg.sv =====
// Types, constants and helper functions of the delayed message queue.
package dmq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = ADDR_W + 2;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 32;
    localparam int TYPE_W      = 8;
    localparam int DELAY_W     = 16;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = ((TYPE_W + DELAY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((TYPE_W + TIME_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [TYPE_W-1:0] kind_t;

    typedef struct packed {
        time_t due;
        kind_t kind;
    } entry_t;

    typedef enum logic [OP_W-1:0] {
        OP_SEND   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TICK   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEND_SCAN,
        ST_SEND_HEAD,
        ST_REM_SCAN,
        ST_TICK_CHK,
        ST_TICK_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NEW_HEAD,
        WR_NEW_NEXT,
        WR_OLD_NEXT,
        WR_KEEP
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    adv_time;
        logic    rd_issue;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    pop;
        logic    clear;
        logic    scan_init;
        logic    remain_dec;
        logic    keep_adv;
        logic    rem_done;
        logic    pend_load;
        logic    out_load;
        logic    out_drop;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic out_free;
        logic new_after;
        logic kind_match;
        logic due_now;
        logic last_step;
        logic pop_last;
        logic n_cap;
        logic pend_any;
    } stat_t;

    // Circular pointer plus offset; offset never exceeds the depth.
    function automatic addr_t ptr_add(addr_t a, cnt_t b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        if (sum >= SUM_W'(QUEUE_DEPTH))
            sum = sum - SUM_W'(QUEUE_DEPTH);
        return sum[ADDR_W-1:0];
    endfunction

    function automatic addr_t ptr_dec(addr_t a);
        if (a == '0)
            return ADDR_W'(QUEUE_DEPTH - 1);
        else
            return a - ADDR_W'(1);
    endfunction

    // Wrap-aware: a is at or before b when b - a has its sign bit clear.
    function automatic logic at_or_before(time_t a, time_t b);
        time_t d;
        d = b - a;
        return ~d[TIME_W-1];
    endfunction

endpackage

// ===== design/delayed_message_queue_top.sv =====
// Top level of the delayed message queue: sequencer plus datapath.
//
//  channel | dir | tdata                            | tuser          | tlast
//  --------+-----+----------------------------------+----------------+------------------
//  s_*     | in  | [7:0] msg_type, [23:8] delay_ms  | [1:0] opcode   | -
//  m_*     | out | [7:0] out_type, [39:8] out_due   | [0] status     | last of the item
//
//  Sequencing: one transaction at a time, accepted and then decoded; a send
//  then walks back from the tail one entry per cycle, a remove walks every
//  queued entry once, and a tick pops due entries from the head one by one,
//  holding while the result register is busy. The pace is set by the single
//  read and single write port of the entry store.
//  Reset: rst_n clears time, head, fill count and the result register at once;
//  stored entries are never read beyond the fill count, so no clearing pass.
//  Stalls: a result waits in the output register; every new result, a dropped
//  send's included, holds the sequencer until the register frees.
module delayed_message_queue_top
    import dmq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input transactions
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] msg_type, [23:8] delay_ms
    input  logic [OP_W-1:0]        s_tuser,   // [1:0] opcode
    // Result transactions
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_type, [39:8] out_due
    output logic                   m_tuser,   // [0] status
    output logic                   m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: decode the opcode, step through the store, hand out results.
    dmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: circular entry store, time counter, compares and result register.
    dmq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/dmq_ctrl.sv =====
// Sequencer of the delayed message queue: issues datapath commands per operation.
module dmq_ctrl
    import dmq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [OP_W-1:0] s_tuser,
    input  stat_t           stat,
    output cmd_t            cmd
);

    state_t  state_reg;
    state_t  state_next;
    opcode_t op_reg;
    opcode_t op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_SEND;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = opcode_t'(s_tuser);
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (op_reg)
                    OP_SEND:
                    begin
                        if (stat.full)
                        begin
                            if (stat.out_free)
                                state_next = ST_IDLE;
                        end
                        else if (stat.empty)
                            state_next = ST_IDLE;
                        else
                            state_next = ST_SEND_SCAN;
                    end
                    OP_REMOVE:
                        state_next = stat.empty ? ST_IDLE : ST_REM_SCAN;
                    OP_CLEAR:
                        state_next = ST_IDLE;
                    OP_TICK:
                        state_next = stat.empty ? ST_IDLE : ST_TICK_CHK;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_SEND_SCAN:
            begin
                if (stat.new_after)
                    state_next = ST_IDLE;
                else if (stat.last_step)
                    state_next = ST_SEND_HEAD;
            end
            ST_SEND_HEAD:
                state_next = ST_IDLE;
            ST_REM_SCAN:
            begin
                if (stat.last_step)
                    state_next = ST_IDLE;
            end
            ST_TICK_CHK:
            begin
                if (stat.due_now && !stat.n_cap)
                begin
                    if ((!stat.pend_any || stat.out_free) && stat.pop_last)
                        state_next = ST_TICK_FLUSH;
                end
                else if (!stat.pend_any || stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_TICK_FLUSH:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load     = 1'b1;
                    cmd.adv_time = (opcode_t'(s_tuser) == OP_TICK);
                end
            end
            ST_DECODE:
            begin
                case (op_reg)
                    OP_SEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.out_load = stat.out_free;
                            cmd.out_drop = 1'b1;
                            cmd.out_last = 1'b1;
                        end
                        else if (stat.empty)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WR_NEW_HEAD;
                            cmd.cnt_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            cmd.rd_issue  = 1'b1;
                            cmd.rd_sel    = RD_TAIL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.scan_init = 1'b1;
                            cmd.rd_issue  = 1'b1;
                            cmd.rd_sel    = RD_HEAD;
                        end
                    end
                    OP_CLEAR:
                        cmd.clear = 1'b1;
                    OP_TICK:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.rd_issue = 1'b1;
                            cmd.rd_sel   = RD_HEAD;
                        end
                    end
                    default:
                        cmd.clear = 1'b0;
                endcase
            end
            ST_SEND_SCAN:
            begin
                cmd.wr_en = 1'b1;
                if (stat.new_after)
                begin
                    cmd.wr_sel  = WR_NEW_NEXT;
                    cmd.cnt_inc = 1'b1;
                end
                else
                begin
                    cmd.wr_sel     = WR_OLD_NEXT;
                    cmd.remain_dec = 1'b1;
                    cmd.rd_issue   = !stat.last_step;
                    cmd.rd_sel     = RD_PREV;
                end
            end
            ST_SEND_HEAD:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_NEW_HEAD;
                cmd.cnt_inc = 1'b1;
            end
            ST_REM_SCAN:
            begin
                cmd.remain_dec = 1'b1;
                cmd.wr_en      = !stat.kind_match;
                cmd.wr_sel     = WR_KEEP;
                cmd.keep_adv   = !stat.kind_match;
                cmd.rem_done   = stat.last_step;
                cmd.rd_issue   = !stat.last_step;
                cmd.rd_sel     = RD_NEXT;
            end
            ST_TICK_CHK:
            begin
                if (stat.due_now && !stat.n_cap)
                begin
                    if (!stat.pend_any || stat.out_free)
                    begin
                        cmd.out_load  = stat.pend_any;
                        cmd.pend_load = 1'b1;
                        cmd.pop       = 1'b1;
                        cmd.rd_issue  = !stat.pop_last;
                        cmd.rd_sel    = RD_NEXT;
                    end
                end
                else
                begin
                    cmd.out_load = stat.pend_any && stat.out_free;
                    cmd.out_last = 1'b1;
                end
            end
            ST_TICK_FLUSH:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_last = 1'b1;
            end
            default:
                s_tready = 1'b0;
        endcase
    end

endmodule

// ===== design/dmq_datapath.sv =====
// Datapath of the delayed message queue: entry store, pointers, time and result register.
module dmq_datapath
    import dmq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] msg_type, [23:8] delay_ms
    input  cmd_t                   cmd,
    output stat_t                  stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_type, [39:8] out_due
    output logic                   m_tuser,   // [0] status
    output logic                   m_tlast
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    time_t  now_reg,       now_next;
    time_t  due_reg,       due_next;
    kind_t  type_reg,      type_next;
    addr_t  head_reg,      head_next;
    cnt_t   count_reg,     count_next;
    addr_t  idx_reg;
    cnt_t   remain_reg,    remain_next;
    addr_t  keep_reg,      keep_next;
    cnt_t   kept_reg,      kept_next;
    entry_t pend_reg,      pend_next;
    logic [NRES_W-1:0] nres_reg, nres_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_status_reg, out_status_next;
    logic   out_last_reg,  out_last_next;
    entry_t out_entry_reg, out_entry_next;

    addr_t  rd_addr;
    addr_t  wr_addr;
    entry_t wr_data;
    entry_t new_entry;
    cnt_t   kept_sum;

    assign new_entry = '{due: due_reg, kind: type_reg};
    assign kept_sum  = kept_reg + CNT_W'(cmd.keep_adv);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD: rd_addr = head_reg;
            RD_TAIL: rd_addr = ptr_add(head_reg, count_reg - CNT_W'(1));
            RD_PREV: rd_addr = ptr_dec(idx_reg);
            RD_NEXT: rd_addr = ptr_add(idx_reg, CNT_W'(1));
            default: rd_addr = head_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_NEW_HEAD:
            begin
                wr_addr = head_reg;
                wr_data = new_entry;
            end
            WR_NEW_NEXT:
            begin
                wr_addr = ptr_add(idx_reg, CNT_W'(1));
                wr_data = new_entry;
            end
            WR_OLD_NEXT:
            begin
                wr_addr = ptr_add(idx_reg, CNT_W'(1));
                wr_data = rd_data_reg;
            end
            WR_KEEP:
            begin
                wr_addr = keep_reg;
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = head_reg;
                wr_data = new_entry;
            end
        endcase
    end

    // Entry store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
            idx_reg     <= rd_addr;
        end
    end

    always_comb
    begin
        stat.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty      = (count_reg == '0);
        stat.out_free   = !out_valid_reg || m_tready;
        stat.new_after  = at_or_before(rd_data_reg.due, due_reg);
        stat.kind_match = (rd_data_reg.kind == type_reg);
        stat.due_now    = at_or_before(rd_data_reg.due, now_reg);
        stat.last_step  = (remain_reg == CNT_W'(1));
        stat.pop_last   = (count_reg == CNT_W'(1));
        stat.n_cap      = (nres_reg >= NRES_W'(MAX_RESULTS));
        stat.pend_any   = (nres_reg != '0);
    end

    always_comb
    begin
        now_next        = now_reg;
        due_next        = due_reg;
        type_next       = type_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        keep_next       = keep_reg;
        kept_next       = kept_reg;
        pend_next       = pend_reg;
        nres_next       = nres_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_entry_next  = out_entry_reg;

        if (cmd.load)
        begin
            due_next  = now_reg + TIME_W'(s_tdata[TYPE_W +: DELAY_W]);
            type_next = s_tdata[TYPE_W-1:0];
            nres_next = '0;
        end
        if (cmd.adv_time)
            now_next = now_reg + TIME_W'(1);

        if (cmd.clear)
            count_next = '0;
        else if (cmd.cnt_inc)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - CNT_W'(1);
        else if (cmd.rem_done)
            count_next = kept_sum;

        if (cmd.pop)
            head_next = ptr_add(head_reg, CNT_W'(1));

        if (cmd.scan_init)
        begin
            remain_next = count_reg;
            keep_next   = head_reg;
            kept_next   = '0;
        end
        if (cmd.remain_dec)
            remain_next = remain_reg - CNT_W'(1);
        if (cmd.keep_adv)
        begin
            keep_next = ptr_add(keep_reg, CNT_W'(1));
            kept_next = kept_sum;
        end

        if (cmd.pend_load)
        begin
            pend_next = rd_data_reg;
            nres_next = nres_reg + NRES_W'(1);
        end

        // The result register frees as soon as the sink takes it.
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.out_drop;
            out_last_next   = cmd.out_last;
            out_entry_next  = cmd.out_drop ? new_entry : pend_reg;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            nres_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            now_reg       <= now_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            nres_reg      <= nres_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg        <= due_next;
        type_reg       <= type_next;
        remain_reg     <= remain_next;
        keep_reg       <= keep_next;
        kept_reg       <= kept_next;
        pend_reg       <= pend_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_entry_reg  <= out_entry_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_TDATA_W'({out_entry_reg.due, out_entry_reg.kind});

endmodule

// ===== design/dmq_checker.sv =====
// Port-level checks of the delayed message queue, bound to the top level.
`include "delayed_message_queue_top_macros.svh"

module dmq_checker
    import dmq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   m_tlast
);

    // Hold a stalled result unchanged.
    `DMQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // A dropped send is always the only result of its transaction.
    `DMQ_ASSERT_NOW(a_drop_last, m_tvalid && m_tuser, m_tlast, "drop result without last")

    // Work on one transaction at a time.
    `DMQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken during decode")

    // While a tick still has results to come, take no new transaction.
    `DMQ_ASSERT_NOW(a_tick_busy, m_tvalid && !m_tlast, !s_tready, "ready during tick dispatch")

endmodule

bind delayed_message_queue_top dmq_checker u_dmq_checker (.*);

// ===== verif/tb_delayed_message_queue_top.sv =====
// Self-checking testbench of the delayed message queue: stream stimulus and a scoreboard.
module tb_delayed_message_queue_top
    import dmq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run bounds: the watchdog limit covers the slowest legal run several times over.
    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 8;
    localparam int TAIL_CYCLES    = 2 * QUEUE_DEPTH + 8;
    localparam int RANDOM_ITEMS   = 245;
    localparam int STEADY_ITEMS   = 40;
    localparam int MAX_PRINTED    = 40;

    typedef logic [DELAY_W-1:0] delay_t;

    // One dispatched or dropped message as it should appear on the result stream.
    typedef struct {
        logic  status;
        kind_t kind;
        time_t due;
        logic  last;
    } dispatch_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;     // [7:0] msg_type, [23:8] delay_ms
    logic [OP_W-1:0]        s_tuser  = '0;     // [1:0] opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [7:0] out_type, [39:8] out_due
    logic                   m_tuser;           // [0] status
    logic                   m_tlast;

    // Shadow copy of the timer queue, kept in step with every accepted transaction.
    time_t     sched_due [QUEUE_DEPTH];
    kind_t     sched_kind[QUEUE_DEPTH];
    int        sched_fill = 0;
    time_t     sched_now  = '0;

    // Dispatches still owed by the block, oldest first.
    dispatch_t awaited_dispatches[$];

    int        items_sent     = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    // Set while a phase runs with no gaps on either side.
    logic      steady         = 1'b0;

    delayed_message_queue_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // True when time a is at or before time b; the sign of the wrapped gap decides.
    function automatic logic reached(time_t a, time_t b);
        time_t gap;
        gap = b - a;
        return ~gap[TIME_W-1];
    endfunction

    // Apply one accepted transaction to the shadow queue and queue up what it owes.
    function automatic void advance_schedule(opcode_t op, kind_t kind, delay_t delay);
        time_t     due;
        int        pos;
        int        keep;
        int        n;
        dispatch_t burst[MAX_RESULTS];
        dispatch_t d;
        n = 0;
        case (op)
            OP_SEND:
            begin
                due = sched_now + time_t'(delay);
                if (sched_fill >= QUEUE_DEPTH)
                begin
                    d.status = 1'b1;
                    d.kind   = kind;
                    d.due    = due;
                    d.last   = 1'b1;
                    awaited_dispatches.push_back(d);
                end
                else
                begin
                    // Insert behind every entry due at or before the new one.
                    pos = 0;
                    while (pos < sched_fill && reached(sched_due[pos], due))
                        pos++;
                    for (int i = sched_fill; i > pos; i--)
                    begin
                        sched_due[i]  = sched_due[i-1];
                        sched_kind[i] = sched_kind[i-1];
                    end
                    sched_due[pos]  = due;
                    sched_kind[pos] = kind;
                    sched_fill++;
                end
            end
            OP_REMOVE:
            begin
                keep = 0;
                for (int i = 0; i < sched_fill; i++)
                begin
                    if (sched_kind[i] != kind)
                    begin
                        sched_due[keep]  = sched_due[i];
                        sched_kind[keep] = sched_kind[i];
                        keep++;
                    end
                end
                sched_fill = keep;
            end
            OP_CLEAR:
                sched_fill = 0;
            default:
            begin
                // Tick: advance time, then pop due entries from the head.
                sched_now = sched_now + 1;
                while (n < MAX_RESULTS && sched_fill > 0 && reached(sched_due[0], sched_now))
                begin
                    burst[n].status = 1'b0;
                    burst[n].kind   = sched_kind[0];
                    burst[n].due    = sched_due[0];
                    burst[n].last   = 1'b0;
                    n++;
                    for (int i = 1; i < sched_fill; i++)
                    begin
                        sched_due[i-1]  = sched_due[i];
                        sched_kind[i-1] = sched_kind[i];
                    end
                    sched_fill--;
                end
                for (int k = 0; k < n; k++)
                begin
                    d      = burst[k];
                    d.last = (k == n - 1);
                    awaited_dispatches.push_back(d);
                end
            end
        endcase
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (steady)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    // Message types from a small pool, so removes and equal types hit often.
    function automatic kind_t pool_kind();
        return kind_t'(8'h10 + $urandom_range(0, 5));
    endfunction

    // Types reserved for far-future messages, so removes can clear them out.
    function automatic kind_t far_kind();
        return kind_t'(8'hF0 + $urandom_range(0, 3));
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Drive one transaction after a random gap and hold it until accepted.
    // Valid stays high after acceptance so a zero gap gives back-to-back items.
    task automatic send_item(input opcode_t op, input kind_t kind, input delay_t delay);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {delay, kind};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_schedule(op, kind, delay);
        items_sent++;
    endtask

    // Stop sending and hold off until every owed dispatch has come, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_dispatches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Field extremes, equal due times, removal of present and absent types, clear, empty ticks.
    task automatic test_edge_fields();
        send_item(OP_TICK,   8'h00, 16'h0000);
        send_item(OP_SEND,   8'h00, 16'h0000);
        send_item(OP_SEND,   8'hFF, 16'hFFFF);
        send_item(OP_SEND,   8'h33, 16'h0000);
        send_item(OP_SEND,   8'hA5, 16'h0000);
        send_item(OP_SEND,   8'h33, 16'h0001);
        send_item(OP_REMOVE, 8'h33, 16'hFFFF);
        send_item(OP_REMOVE, 8'h77, 16'h0000);
        send_item(OP_TICK,   8'hFF, 16'hFFFF);
        send_item(OP_CLEAR,  8'h5A, 16'h5A5A);
        send_item(OP_TICK,   8'h00, 16'h0000);
    endtask

    // Fill the queue, overflow it once, then dispatch the whole queue on one tick.
    task automatic test_full_queue_drop();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_item(OP_SEND, kind_t'(i * 17), delay_t'(i % 2));
        send_item(OP_SEND, 8'hC3, 16'hFFFF);
        send_item(OP_TICK, 8'h00, 16'h0000);
        send_item(OP_TICK, 8'h00, 16'h0000);
    endtask

    // Mostly well-formed schedule-and-tick sequences, with fills, removes, far messages and noise.
    task automatic test_scheduled_traffic();
        int   roll;
        int   n;
        logic paused;
        kind_t kind;
        paused = 1'b0;
        while (items_sent < RANDOM_ITEMS)
        begin
            // Hold the sender once mid-run until the result stream is empty.
            if (!paused && items_sent >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            roll = int'($urandom_range(0, 99));
            if (roll < 35)
            begin
                n = int'($urandom_range(1, 6));
                repeat (n) send_item(OP_SEND, pool_kind(), delay_t'($urandom_range(0, 8)));
                n = int'($urandom_range(1, 4));
                repeat (n) send_item(OP_TICK, kind_t'($urandom), delay_t'($urandom));
            end
            else if (roll < 45)
            begin
                // Top up to full, push past it, then drain a little.
                while (sched_fill < QUEUE_DEPTH)
                    send_item(OP_SEND, pool_kind(), delay_t'($urandom_range(0, 3)));
                n = int'($urandom_range(1, 2));
                repeat (n) send_item(OP_SEND, kind_t'($urandom), delay_t'($urandom));
                n = int'($urandom_range(1, 5));
                repeat (n) send_item(OP_TICK, kind_t'($urandom), delay_t'($urandom));
            end
            else if (roll < 60)
            begin
                n = int'($urandom_range(1, 6));
                repeat (n) send_item(OP_TICK, kind_t'($urandom), delay_t'($urandom));
            end
            else if (roll < 72)
            begin
                // Prefer a type that is queued right now.
                if (sched_fill > 0 && $urandom_range(0, 99) < 60)
                    kind = sched_kind[$urandom_range(0, sched_fill - 1)];
                else if ($urandom_range(0, 1) == 0)
                    kind = far_kind();
                else
                    kind = kind_t'($urandom);
                send_item(OP_REMOVE, kind, delay_t'($urandom));
            end
            else if (roll < 77)
                send_item(OP_CLEAR, kind_t'($urandom), delay_t'($urandom));
            else if (roll < 87)
                send_item(OP_SEND, far_kind(), delay_t'($urandom_range(0, 65535)));
            else
                send_item(opcode_t'($urandom_range(0, 3)), kind_t'($urandom), delay_t'($urandom));
        end
    endtask

    // Send, tick and remove traffic with no gaps on either side.
    task automatic test_back_to_back();
        int n;
        int stop_at;
        stop_at = items_sent + STEADY_ITEMS;
        steady  = 1'b1;
        while (items_sent < stop_at)
        begin
            n = int'($urandom_range(1, 6));
            repeat (n) send_item(OP_SEND, pool_kind(), delay_t'($urandom_range(0, 4)));
            n = int'($urandom_range(1, 3));
            repeat (n) send_item(OP_TICK, kind_t'($urandom), delay_t'($urandom));
            if ($urandom_range(0, 3) == 0)
                send_item(OP_REMOVE, pool_kind(), delay_t'($urandom));
        end
        steady = 1'b0;
    endtask

    // Result side: check each accepted result against the oldest owed dispatch,
    // then pick the ready level for the next cycle.
    initial
    begin : result_monitor
        dispatch_t want;
        int        stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (awaited_dispatches.size() == 0)
                    report_mismatch($sformatf("unexpected result type %0h due %0h status %0b",
                                              m_tdata[TYPE_W-1:0], m_tdata[TYPE_W +: TIME_W],
                                              m_tuser));
                else
                begin
                    want = awaited_dispatches.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status got %0b want %0b",
                                                  m_tuser, want.status));
                    if (m_tdata[TYPE_W-1:0] !== want.kind)
                        report_mismatch($sformatf("out_type got %0h want %0h",
                                                  m_tdata[TYPE_W-1:0], want.kind));
                    if (m_tdata[TYPE_W +: TIME_W] !== want.due)
                        report_mismatch($sformatf("out_due got %0h want %0h",
                                                  m_tdata[TYPE_W +: TIME_W], want.due));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  m_tlast, want.last));
                end
            end
            if (steady)
                m_tready <= 1'b1;
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                // Start a stall; its first cycle is this one.
                m_tready <= 1'b0;
                stall = pick_gap();
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_delayed_message_queue_top: FAIL");
        $finish;
    end

    initial
    begin : test_sequence
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_fields();
        test_full_queue_drop();
        test_scheduled_traffic();
        test_back_to_back();
        // Drain everything owed, then give the block time to show any stray result.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_dispatches.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_dispatches.size()));
        if (mismatch_count == 0)
            $display("tb_delayed_message_queue_top: PASS");
        else
            $display("tb_delayed_message_queue_top: FAIL");
        $finish;
    end

endmodule
